// ----- hdl/wcc_pkg.sv -----
// Shared sizes, codes and types for the windowed code co-occurrence unit.
// No dependencies; imported by every module of the block.
package wcc_pkg;

    localparam int NUM_CODES   = 8;
    localparam int MAX_WINDOW  = 16;

    localparam int CODE_W      = 8;
    localparam int ROW_W       = 64;
    localparam int SUM_W       = 24;
    localparam int VAL_W       = 34;
    localparam int IDX_W       = 3;
    localparam int WIN_W       = 5;

    localparam int HIST_DEPTH  = MAX_WINDOW - 1;
    localparam int SLOT_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HELD_W      = $clog2(HIST_DEPTH + 1);
    localparam int CMP_W       = (WIN_W > HELD_W) ? WIN_W : HELD_W;
    localparam int ACC_W       = $clog2(HIST_DEPTH * ((1 << CODE_W) - 1) + 1);
    localparam int LANE_BITS   = NUM_CODES * CODE_W;
    localparam int CIDX_W      = $clog2(NUM_CODES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int OUT_DATA_W  = ((VAL_W + 2 * IDX_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_ROWS  = 2'd0,
        CFG_UNLIMITED    = 2'd1,
        CFG_BINARY_OUT   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SUM,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [WIN_W-1:0] window_rows;
        logic             unlimited;
        logic             binary_out;
    } t_cfg;

    typedef struct packed {
        logic [NUM_CODES-1:0][SUM_W-1:0]  refs;
        logic [NUM_CODES-1:0][CODE_W-1:0] codes;
    } t_job;

endpackage

// ----- hdl/wcc_front.sv -----
// Front end: accepts rows, sums the backward window from the history RAM (running
// sums if unlimited) and hands {row, reference sums} to the job queue. Depends on wcc_pkg.
module wcc_front
    import wcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [LANE_BITS-1:0] i_row,
    input  logic                 i_new_seq,
    output logic                 o_push,
    output t_job                 o_job,
    input  logic                 i_q_ready
);

    t_front_state r_state, n_state;

    logic [LANE_BITS-1:0] r_row, n_row;
    logic [HELD_W-1:0]    r_left, n_left;
    logic [SLOT_W-1:0]    r_rd_slot, n_rd_slot;
    logic                 r_rd_pend, n_rd_pend;
    logic [ACC_W-1:0]     r_acc [NUM_CODES];
    logic [ACC_W-1:0]     n_acc [NUM_CODES];
    logic [SUM_W-1:0]     r_prior [NUM_CODES];
    logic [SUM_W-1:0]     n_prior [NUM_CODES];
    logic [HELD_W-1:0]    r_held, n_held;
    logic [SLOT_W-1:0]    r_slot, n_slot;

    logic [LANE_BITS-1:0] r_mem [HIST_DEPTH];
    logic [LANE_BITS-1:0] r_mem_q;
    logic                 mem_re;
    logic                 mem_we;

    logic [HELD_W-1:0]    eff_held;
    logic [SLOT_W-1:0]    eff_slot;
    logic [CMP_W-1:0]     lb_ext;
    logic [CMP_W-1:0]     held_ext;
    logic [HELD_W-1:0]    look_rows;
    logic [SLOT_W-1:0]    start_slot;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CODE_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    assign o_in_ready = (r_state == FS_IDLE);

    always_comb begin
        eff_held   = i_new_seq ? '0 : r_held;
        eff_slot   = i_new_seq ? '0 : r_slot;
        lb_ext     = (i_cfg.window_rows == '0) ? '0 : CMP_W'(i_cfg.window_rows - 1'b1);
        held_ext   = CMP_W'(eff_held);
        if (i_cfg.unlimited) begin
            look_rows = '0;
        end else if (lb_ext < held_ext) begin
            look_rows = HELD_W'(lb_ext);
        end else begin
            look_rows = eff_held;
        end
        start_slot = (eff_slot == '0) ? SLOT_W'(HIST_DEPTH - 1) : eff_slot - 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_left    = r_left;
        n_rd_slot = r_rd_slot;
        n_rd_pend = 1'b0;
        n_acc     = r_acc;
        n_prior   = r_prior;
        n_held    = r_held;
        n_slot    = r_slot;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        o_push    = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    n_row     = i_row;
                    n_held    = eff_held;
                    n_slot    = eff_slot;
                    n_left    = look_rows;
                    n_rd_slot = start_slot;
                    for (int k = 0; k < NUM_CODES; k++) begin
                        n_acc[k] = '0;
                        if (i_new_seq) begin
                            n_prior[k] = '0;
                        end
                    end
                    n_state = FS_SUM;
                end
            end
            FS_SUM: begin
                if (r_rd_pend) begin
                    for (int k = 0; k < NUM_CODES; k++) begin
                        n_acc[k] = r_acc[k] + ACC_W'(r_mem_q[k*CODE_W +: CODE_W]);
                    end
                end
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_left    = r_left - 1'b1;
                    n_rd_slot = (r_rd_slot == '0) ? SLOT_W'(HIST_DEPTH - 1)
                                                  : r_rd_slot - 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                o_push = 1'b1;
                if (i_q_ready) begin
                    mem_we = 1'b1;
                    for (int k = 0; k < NUM_CODES; k++) begin
                        n_prior[k] = sat_add(r_prior[k], r_row[k*CODE_W +: CODE_W]);
                    end
                    n_slot = (r_slot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    if (r_held != HELD_W'(HIST_DEPTH)) begin
                        n_held = r_held + 1'b1;
                    end
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < NUM_CODES; k++) begin
            o_job.codes[k] = r_row[k*CODE_W +: CODE_W];
            o_job.refs[k]  = i_cfg.unlimited ? r_prior[k] : SUM_W'(r_acc[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_IDLE;
            r_rd_pend <= 1'b0;
            r_left    <= '0;
            r_held    <= '0;
            r_slot    <= '0;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_prior[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_left    <= n_left;
            r_held    <= n_held;
            r_slot    <= n_slot;
            r_prior   <= n_prior;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_rd_slot <= n_rd_slot;
        r_acc     <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= r_row;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_rd_slot];
        end
    end

endmodule

// ----- hdl/wcc_queue.sv -----
// Short job queue between the front end and the pair generator.
// Depends on wcc_pkg for the job type and depth.
module wcc_queue
    import wcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_buf[r_rp];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_job;
        end
    end

endmodule

// ----- hdl/wcc_back.sv -----
// Back end: walks the code pairs of one job and drives the registered
// result stage. Depends on wcc_pkg.
module wcc_back
    import wcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_job             i_q_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_value,
    output logic [IDX_W-1:0] o_first,
    output logic [IDX_W-1:0] o_second,
    output logic             o_last
);

    logic              r_have;
    t_job              r_job;
    logic [CIDX_W-1:0] r_j;
    logic [CIDX_W-1:0] r_k;

    logic              r_ov;
    logic [VAL_W-1:0]  r_oval;
    logic [IDX_W-1:0]  r_ofirst;
    logic [IDX_W-1:0]  r_osecond;
    logic              r_olast;

    logic [CODE_W-1:0]       xj;
    logic [CODE_W-1:0]       xk;
    logic [SUM_W-1:0]        rj;
    logic [SUM_W-1:0]        rk;
    logic [SUM_W:0]          rk_plus;
    logic [SUM_W+CODE_W-1:0] prod_a;
    logic [SUM_W+CODE_W:0]   prod_b;
    logic [VAL_W-1:0]        v_sum;
    logic [VAL_W-1:0]        v_out;
    logic                    is_last;
    logic                    pair_end;
    logic                    adv;
    logic                    take;

    assign xj       = r_job.codes[r_j];
    assign xk       = r_job.codes[r_k];
    assign rj       = r_job.refs[r_j];
    assign rk       = r_job.refs[r_k];
    assign rk_plus  = {1'b0, rk} + (SUM_W + 1)'(xk);
    assign prod_a   = rj * xk;
    assign prod_b   = rk_plus * xj;
    assign v_sum    = VAL_W'(prod_a) + VAL_W'(prod_b);
    assign v_out    = (i_cfg.binary_out && v_sum != '0) ? VAL_W'(1) : v_sum;

    assign pair_end = (r_j + 1'b1 == r_k);
    assign is_last  = pair_end && (r_k == CIDX_W'(NUM_CODES - 1));
    assign adv      = r_have & (~r_ov | i_ready);
    assign take     = i_q_valid & (~r_have | (adv & is_last));
    assign o_pop    = take;

    assign o_valid  = r_ov;
    assign o_value  = r_oval;
    assign o_first  = r_ofirst;
    assign o_second = r_osecond;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (take) begin
                r_have <= 1'b1;
            end else if (adv && is_last) begin
                r_have <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
            r_j   <= '0;
            r_k   <= CIDX_W'(1);
        end else if (adv) begin
            if (pair_end) begin
                r_j <= '0;
                r_k <= r_k + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (adv) begin
            r_oval    <= v_out;
            r_ofirst  <= IDX_W'(r_j);
            r_osecond <= IDX_W'(r_k);
            r_olast   <= is_last;
        end
    end

endmodule

// ----- hdl/windowed_code_cooccurrence_unit.sv -----
// Top level of the windowed code co-occurrence unit: configuration
// registers, front end, job queue and pair generator. Depends on wcc_pkg.
//
// Each row item yields 28 pair items, one per cycle while the output is not
// stalled; the pair generator limits the rate. The front end reads one
// history row per row in the backward window (up to 15, one read of the
// single-port history RAM a cycle), and works on the next row while the
// previous one is still being emitted. No clearing pass is needed after reset.
module windowed_code_cooccurrence_unit
    import wcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WIN_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [ROW_W-1:0]      i_s_axis_tdata,   // row_codes
    input  logic                  i_s_axis_tuser,   // new_sequence
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // pair_value, first_code, second_code
    output logic                  o_m_axis_tlast    // last_pair
);

    t_cfg             r_cfg;
    logic             push;
    t_job             push_job;
    logic             q_ready;
    logic             q_valid;
    t_job             q_job;
    logic             pop;
    logic [VAL_W-1:0] pair_value;
    logic [IDX_W-1:0] first_code;
    logic [IDX_W-1:0] second_code;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_rows <= WIN_W'(1);
            r_cfg.unlimited   <= 1'b0;
            r_cfg.binary_out  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_ROWS: r_cfg.window_rows <= i_cfg_data;
                CFG_UNLIMITED:   r_cfg.unlimited   <= i_cfg_data[0];
                CFG_BINARY_OUT:  r_cfg.binary_out  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    wcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_row      (i_s_axis_tdata[LANE_BITS-1:0]),
        .i_new_seq  (i_s_axis_tuser),
        .o_push     (push),
        .o_job      (push_job),
        .i_q_ready  (q_ready)
    );

    wcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    wcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_value   (pair_value),
        .o_first   (first_code),
        .o_second  (second_code),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({second_code, first_code, pair_value});

endmodule
